>>> src/gscw_pkg.sv
// ----------------------------------------------------------------------------
// gscw_pkg
// Shared constants, codes and widths for the spiral grid coverage walk.
// ----------------------------------------------------------------------------
`default_nettype none

package gscw_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int DEPTH      = MAX_COLS * MAX_ROWS;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int COST_W     = 8;
    localparam int IDX_W      = 12;
    localparam int DIM_W      = 7;
    localparam int START_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_ROW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VISITED    = 3'd6;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_WALK = 2'd1;
    localparam logic [1:0] PHASE_DONE = 2'd2;

endpackage

`default_nettype wire

>>> src/gscw_in_if.sv
// ----------------------------------------------------------------------------
// gscw_in_if
// Command request channel: load a cost cell or advance the walk.
// ----------------------------------------------------------------------------
`default_nettype none

interface gscw_in_if import gscw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [COST_W-1:0] cell_cost;

    modport source (output valid, cmd, cell_cost, input ready);
    modport sink   (input valid, cmd, cell_cost, output ready);
endinterface

`default_nettype wire

>>> src/gscw_out_if.sv
// ----------------------------------------------------------------------------
// gscw_out_if
// Path cell request channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface gscw_out_if import gscw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] path_col;
    logic [ROW_W-1:0] path_row;
    logic [IDX_W-1:0] path_index;
    logic             is_last;
    logic             walk_done;

    modport source (output valid, path_col, path_row, path_index, is_last, walk_done,
                    input ready);
    modport sink   (input valid, path_col, path_row, path_index, is_last, walk_done,
                    output ready);
endinterface

`default_nettype wire

>>> src/gscw_cfg_if.sv
// ----------------------------------------------------------------------------
// gscw_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface gscw_cfg_if import gscw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/grid_spiral_coverage_walk_core.sv
// ----------------------------------------------------------------------------
// grid_spiral_coverage_walk_core
// Spiral coverage walk over a loaded grid of cost bytes.
// ----------------------------------------------------------------------------
// A load request writes one cost byte row-major; it also restarts the walk.
// A step request returns one path cell: it places the current cell, writes
// the visited mark, then per tried direction skips a neighbour off the map or
// reads it and tests it for free, and last hands over the result, waiting
// while the path channel stalls. A step after the walk has ended hands over
// a finished-walk marker. The steps are set by the single-port cost memory,
// which does one access per cycle, and by the shared row times width address
// multiplier. Every cell must be loaded before stepping.
`default_nettype none

module grid_spiral_coverage_walk_core import gscw_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    gscw_in_if.sink       items,
    gscw_out_if.source    path,
    gscw_cfg_if.sink      cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MARK  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic [1:0]         heading_reg, heading_next;
    logic [1:0]         dir_reg, dir_next;
    logic [1:0]         tries_reg, tries_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [IDX_W-1:0]   step_cnt_reg, step_cnt_next;
    logic [ADDR_W-1:0]  load_ptr_reg, load_ptr_next;
    logic               out_valid_reg, out_valid_next;

    logic [COL_W-1:0]   nb_col_reg, nb_col_next;
    logic [ROW_W-1:0]   nb_row_reg, nb_row_next;
    logic [COL_W-1:0]   res_col_reg, res_col_next;
    logic [ROW_W-1:0]   res_row_reg, res_row_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic               res_last_reg, res_last_next;
    logic               res_done_reg, res_done_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic               out_last_reg, out_last_next;
    logic               out_done_reg, out_done_next;

    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [START_W-1:0] start_col_reg, start_row_reg;
    logic [COST_W-1:0]  thresh_reg, unknown_reg, visited_reg;

    logic [COL_W-1:0]   w_last;
    logic [ROW_W-1:0]   h_last;
    logic [COL_W:0]     w_eff;
    logic [COL_W-1:0]   src_col, clamp_col;
    logic [ROW_W-1:0]   src_row, clamp_row;
    logic               inb;
    logic [COL_W-1:0]   nb_col;
    logic [ROW_W-1:0]   nb_row;
    logic [COL_W-1:0]   mul_col;
    logic [ROW_W-1:0]   mul_row;
    logic [ROW_W+COL_W:0] prod;
    logic [ADDR_W-1:0]  grid_addr;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [COST_W-1:0]  ram_wdata, ram_rdata;
    logic               cell_free;
    logic               in_acc, out_free;

    gscw_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // effective map extents, minus one
    always_comb
    begin
        priority if (width_reg == '0)
            w_last = '0;
        else if (32'(width_reg) > MAX_COLS)
            w_last = COL_W'(MAX_COLS - 1);
        else
            w_last = COL_W'(width_reg - DIM_W'(1));

        priority if (height_reg == '0)
            h_last = '0;
        else if (32'(height_reg) > MAX_ROWS)
            h_last = ROW_W'(MAX_ROWS - 1);
        else
            h_last = ROW_W'(height_reg - DIM_W'(1));
    end

    assign w_eff = {1'b0, w_last} + (COL_W+1)'(1);

    always_comb
    begin
        src_col   = (phase_reg == PHASE_IDLE) ? COL_W'(start_col_reg) : cur_col_reg;
        src_row   = (phase_reg == PHASE_IDLE) ? ROW_W'(start_row_reg) : cur_row_reg;
        clamp_col = (src_col > w_last) ? w_last : src_col;
        clamp_row = (src_row > h_last) ? h_last : src_row;
    end

    always_comb
    begin
        nb_col = cur_col_reg;
        nb_row = cur_row_reg;
        unique case (dir_reg)
            DIR_UP:
            begin
                inb    = (cur_row_reg != '0);
                nb_row = cur_row_reg - ROW_W'(1);
            end
            DIR_RIGHT:
            begin
                inb    = (cur_col_reg < w_last);
                nb_col = cur_col_reg + COL_W'(1);
            end
            DIR_DOWN:
            begin
                inb    = (cur_row_reg < h_last);
                nb_row = cur_row_reg + ROW_W'(1);
            end
            default:
            begin
                inb    = (cur_col_reg != '0);
                nb_col = cur_col_reg - COL_W'(1);
            end
        endcase
    end

    // shared address unit: row * width + col
    assign mul_col   = (state_reg == S_PROBE) ? nb_col : cur_col_reg;
    assign mul_row   = (state_reg == S_PROBE) ? nb_row : cur_row_reg;
    assign prod      = (ROW_W+COL_W+1)'(mul_row) * (ROW_W+COL_W+1)'(w_eff);
    assign grid_addr = ADDR_W'(prod) + ADDR_W'(mul_col);

    assign cell_free = (ram_rdata < thresh_reg) || (ram_rdata == unknown_reg);

    assign in_acc   = items.valid && items.ready;
    assign out_free = !out_valid_reg || path.ready;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        heading_next  = heading_reg;
        dir_next      = dir_reg;
        tries_next    = tries_reg;
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        step_cnt_next = step_cnt_reg;
        load_ptr_next = load_ptr_reg;
        nb_col_next   = nb_col_reg;
        nb_row_next   = nb_row_reg;
        res_col_next  = res_col_reg;
        res_row_next  = res_row_reg;
        res_idx_next  = res_idx_reg;
        res_last_next = res_last_reg;
        res_done_next = res_done_reg;
        ram_we        = 1'b0;
        ram_addr      = grid_addr;
        ram_wdata     = visited_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (items.cmd == CMD_LOAD)
                    begin
                        ram_we        = 1'b1;
                        ram_addr      = load_ptr_reg;
                        ram_wdata     = items.cell_cost;
                        load_ptr_next = load_ptr_reg + ADDR_W'(1);
                        phase_next    = PHASE_IDLE;
                        heading_next  = DIR_UP;
                        step_cnt_next = '0;
                    end
                    else if (phase_reg == PHASE_DONE)
                    begin
                        res_col_next  = '0;
                        res_row_next  = '0;
                        res_idx_next  = '0;
                        res_last_next = 1'b0;
                        res_done_next = 1'b1;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                cur_col_next = clamp_col;
                cur_row_next = clamp_row;
                if (phase_reg == PHASE_IDLE)
                begin
                    heading_next = DIR_UP;
                    phase_next   = PHASE_WALK;
                end
                state_next = S_MARK;
            end
            S_MARK:
            begin
                ram_we        = 1'b1;
                res_col_next  = cur_col_reg;
                res_row_next  = cur_row_reg;
                res_idx_next  = step_cnt_reg;
                res_done_next = 1'b0;
                step_cnt_next = step_cnt_reg + IDX_W'(1);
                dir_next      = heading_reg;
                tries_next    = '0;
                state_next    = S_PROBE;
            end
            S_PROBE:
            begin
                nb_col_next = nb_col;
                nb_row_next = nb_row;
                if (inb)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    tries_next = tries_reg + 2'd1;
                    if (tries_reg == 2'd3)
                    begin
                        res_last_next = 1'b1;
                        phase_next    = PHASE_DONE;
                        state_next    = S_FIN;
                    end
                end
            end
            S_CHECK:
            begin
                if (cell_free)
                begin
                    cur_col_next  = nb_col_reg;
                    cur_row_next  = nb_row_reg;
                    heading_next  = dir_reg;
                    res_last_next = 1'b0;
                    state_next    = S_FIN;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    tries_next = tries_reg + 2'd1;
                    if (tries_reg == 2'd3)
                    begin
                        res_last_next = 1'b1;
                        phase_next    = PHASE_DONE;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (path.valid && path.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_valid_next = 1'b1;
            out_col_next   = res_col_reg;
            out_row_next   = res_row_reg;
            out_idx_next   = res_idx_reg;
            out_last_next  = res_last_reg;
            out_done_next  = res_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PHASE_IDLE;
            heading_reg   <= DIR_UP;
            dir_reg       <= DIR_UP;
            tries_reg     <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            step_cnt_reg  <= '0;
            load_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= DIM_W'(64);
            height_reg    <= DIM_W'(64);
            start_col_reg <= '0;
            start_row_reg <= '0;
            thresh_reg    <= COST_W'(253);
            unknown_reg   <= COST_W'(255);
            visited_reg   <= COST_W'(254);
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            heading_reg   <= heading_next;
            dir_reg       <= dir_next;
            tries_reg     <= tries_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            step_cnt_reg  <= step_cnt_next;
            load_ptr_reg  <= load_ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_MAP_WIDTH:  width_reg     <= cfg.data[DIM_W-1:0];
                    REG_MAP_HEIGHT: height_reg    <= cfg.data[DIM_W-1:0];
                    REG_START_COL:  start_col_reg <= cfg.data[START_W-1:0];
                    REG_START_ROW:  start_row_reg <= cfg.data[START_W-1:0];
                    REG_THRESHOLD:  thresh_reg    <= cfg.data;
                    REG_UNKNOWN:    unknown_reg   <= cfg.data;
                    REG_VISITED:    visited_reg   <= cfg.data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nb_col_reg   <= nb_col_next;
        nb_row_reg   <= nb_row_next;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_idx_reg  <= res_idx_next;
        res_last_reg <= res_last_next;
        res_done_reg <= res_done_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign items.ready     = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign path.valid      = out_valid_reg;
    assign path.path_col   = out_col_reg;
    assign path.path_row   = out_row_reg;
    assign path.path_index = out_idx_reg;
    assign path.is_last    = out_last_reg;
    assign path.walk_done  = out_done_reg;

    a_last_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        path.valid |-> !(path.is_last && path.walk_done))
        else $error("last cell flagged on a finished walk");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (path.valid && path.walk_done) |->
            (path.path_col == '0 && path.path_row == '0 && path.path_index == '0))
        else $error("finished walk reports a cell");

    a_cur_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (cur_col_reg <= w_last && cur_row_reg <= h_last))
        else $error("current cell outside the map");

    a_mark_walking: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK) |-> (phase_reg == PHASE_WALK))
        else $error("visited mark written outside a walk");

endmodule

`default_nettype wire

>>> src/gscw_ram.sv
// ----------------------------------------------------------------------------
// gscw_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gscw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire
